[rtl/efss_pkg.sv]
// ----------------------------------------------------------------------------
// efss_pkg
// Shared types and constants for the earliest free server select unit.
// ----------------------------------------------------------------------------
package efss_pkg;

   localparam int unsigned FIELD_W   = 5;
   localparam int unsigned SERVICE_W = 16;

   typedef enum logic {
      OP_CLEAR = 1'b0,
      OP_JOB   = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN1,
      ST_CHECK,
      ST_SCAN2
   } state_type;

   typedef struct packed {
      logic load;
      logic clear_used;
      logic write_fresh;
      logic write_acc;
      logic scan_start;
      logic resp_clear;
      logic resp_direct;
      logic resp_scan;
   } cmd_type;

   typedef struct packed {
      logic is_job;
      logic used_lt_n;
      logic scan_done;
   } status_type;

endpackage

[rtl/earliest_free_server_select_unit.sv]
// ----------------------------------------------------------------------------
// earliest_free_server_select_unit
// Assigns jobs to the lowest unused server, then to the earliest finishing
// one, keeping saturating finish times per server.
//
// Usage:
//  - command channel: req_opcode/req_service_time are taken when start is
//    high and busy is low; a clear opcode starts a new batch
//  - result channel: one beat per command, valid while rsp_strobe is high for
//    exactly one cycle; the receiver cannot stall it
//  - csr channel: csr_num_servers is written when csr_valid and csr_ready are
//    high (csr_ready is always high); write it only while the unit is idle
//  - order of work: a clear answers from dispatch; a job that leaves an unused
//    server answers after the check; a job that takes the last unused server
//    runs one scan, and once all are used a job runs two; a scan reads the
//    finish time memory one entry per cycle, so it may run twice per job
//    (pick and next-server lookup)
//  - busy stays high until the cycle the strobe is shown; one command at a time
//  - reset: batch empty, server count 1; finish times are only read after
//    they are written in the current batch, so the memory is not cleared
// ----------------------------------------------------------------------------
module earliest_free_server_select_unit #(
   parameter int unsigned MAX_SERVERS = 16,
   parameter int unsigned TIME_BITS   = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_opcode,
   input  logic [efss_pkg::SERVICE_W-1:0]  req_service_time,
   output logic                            rsp_strobe,
   output logic [efss_pkg::FIELD_W-1:0]    rsp_assigned_server,
   output logic [efss_pkg::FIELD_W-1:0]    rsp_next_server,
   output logic                            rsp_time_saturated,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [efss_pkg::FIELD_W-1:0]    csr_num_servers
);

   efss_pkg::cmd_type    cmd;
   efss_pkg::status_type status;

   efss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   efss_datapath #(
      .MAX_SERVERS (MAX_SERVERS),
      .TIME_BITS   (TIME_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_opcode          (req_opcode),
      .req_service_time    (req_service_time),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_num_servers     (csr_num_servers),
      .cmd                 (cmd),
      .status              (status),
      .rsp_strobe          (rsp_strobe),
      .rsp_assigned_server (rsp_assigned_server),
      .rsp_next_server     (rsp_next_server),
      .rsp_time_saturated  (rsp_time_saturated)
   );

endmodule

[rtl/efss_ctrl.sv]
// ----------------------------------------------------------------------------
// efss_ctrl
// Sequencer: dispatches clear and job items, runs the finish time scans and
// issues the result beat.
// ----------------------------------------------------------------------------
module efss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  efss_pkg::status_type status,
   output efss_pkg::cmd_type    cmd
);

   efss_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= efss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         efss_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = efss_pkg::ST_DISPATCH;
            end
         end
         efss_pkg::ST_DISPATCH: begin
            if (!status.is_job) begin
               cmd.clear_used = 1'b1;
               cmd.resp_clear = 1'b1;
               state_in       = efss_pkg::ST_IDLE;
            end else if (status.used_lt_n) begin
               cmd.write_fresh = 1'b1;
               state_in        = efss_pkg::ST_CHECK;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = efss_pkg::ST_SCAN1;
            end
         end
         efss_pkg::ST_SCAN1: begin
            if (status.scan_done) begin
               cmd.write_acc = 1'b1;
               state_in      = efss_pkg::ST_CHECK;
            end
         end
         efss_pkg::ST_CHECK: begin
            if (status.used_lt_n) begin
               cmd.resp_direct = 1'b1;
               state_in        = efss_pkg::ST_IDLE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = efss_pkg::ST_SCAN2;
            end
         end
         efss_pkg::ST_SCAN2: begin
            if (status.scan_done) begin
               cmd.resp_scan = 1'b1;
               state_in      = efss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = efss_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/efss_datapath.sv]
// ----------------------------------------------------------------------------
// efss_datapath
// Finish time memory, minimum scan, saturating update, server count
// register and result registers.
// ----------------------------------------------------------------------------
module efss_datapath #(
   parameter int unsigned MAX_SERVERS = 16,
   parameter int unsigned TIME_BITS   = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_opcode,
   input  logic [efss_pkg::SERVICE_W-1:0]        req_service_time,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [efss_pkg::FIELD_W-1:0]          csr_num_servers,
   input  efss_pkg::cmd_type                     cmd,
   output efss_pkg::status_type                  status,
   output logic                                  rsp_strobe,
   output logic [efss_pkg::FIELD_W-1:0]          rsp_assigned_server,
   output logic [efss_pkg::FIELD_W-1:0]          rsp_next_server,
   output logic                                  rsp_time_saturated
);

   localparam int unsigned IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_SERVERS + 1);
   localparam int unsigned CW    = (CNT_W > efss_pkg::FIELD_W) ? CNT_W : efss_pkg::FIELD_W;
   localparam int unsigned SW    = (CNT_W + 1 > efss_pkg::FIELD_W) ? CNT_W + 1
                                                                    : efss_pkg::FIELD_W;

   logic [efss_pkg::FIELD_W-1:0]   num_servers_ff;
   logic [CW-1:0]                  nreg_ext;
   logic [CNT_W-1:0]               n_eff;

   logic                           opcode_ff;
   logic [efss_pkg::SERVICE_W-1:0] dur_ff;
   logic [CNT_W-1:0]               used_ff;

   logic [TIME_BITS-1:0]           mem [MAX_SERVERS];
   logic                           scan_act_ff;
   logic [CNT_W-1:0]               cnt_ff;
   logic                           issue;
   logic                           rd_vld_ff;
   logic [IDX_W-1:0]               rd_idx_ff;
   logic [TIME_BITS-1:0]           rdata_ff;
   logic                           best_has_ff;
   logic [IDX_W-1:0]               best_idx_ff;
   logic [TIME_BITS-1:0]           best_val_ff;

   logic                           wr_en;
   logic [IDX_W-1:0]               wr_idx;
   logic [TIME_BITS-1:0]           base;
   logic [TIME_BITS:0]             sum;
   logic [TIME_BITS-1:0]           t_new;
   logic [IDX_W-1:0]               asgn_ff;
   logic                           sat_ff;

   logic [SW-1:0]                  asgn_num;
   logic [SW-1:0]                  used_num;
   logic [SW-1:0]                  best_num;

   logic                           rsp_strobe_ff;
   logic [efss_pkg::FIELD_W-1:0]   rsp_asgn_ff;
   logic [efss_pkg::FIELD_W-1:0]   rsp_next_ff;
   logic                           rsp_sat_ff;

   // server count register; the effective count is clamped to 1..MAX_SERVERS
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_servers_ff <= efss_pkg::FIELD_W'(1);
      end else if (csr_valid && csr_ready) begin
         num_servers_ff <= csr_num_servers;
      end
   end

   always_comb begin
      nreg_ext = CW'(num_servers_ff);
      if (nreg_ext == '0) begin
         n_eff = CNT_W'(1);
      end else if (nreg_ext > CW'(MAX_SERVERS)) begin
         n_eff = CNT_W'(MAX_SERVERS);
      end else begin
         n_eff = nreg_ext[CNT_W-1:0];
      end
   end

   // item latch and batch fill count
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opcode_ff <= req_opcode;
         dur_ff    <= req_service_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.clear_used) begin
         used_ff <= '0;
      end else if (cmd.write_fresh) begin
         used_ff <= used_ff + CNT_W'(1);
      end
   end

   // minimum scan over the first n entries
   assign issue = scan_act_ff && (cnt_ff < n_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_act_ff <= 1'b0;
         rd_vld_ff   <= 1'b0;
         best_has_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         rd_vld_ff <= issue;
         if (cmd.scan_start) begin
            scan_act_ff <= 1'b1;
            best_has_ff <= 1'b0;
            cnt_ff      <= '0;
         end else begin
            if (issue) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
            if (status.scan_done) begin
               scan_act_ff <= 1'b0;
            end
            if (rd_vld_ff) begin
               best_has_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff  <= mem[cnt_ff[IDX_W-1:0]];
      rd_idx_ff <= cnt_ff[IDX_W-1:0];
      if (rd_vld_ff && (!best_has_ff || (rdata_ff < best_val_ff))) begin
         best_val_ff <= rdata_ff;
         best_idx_ff <= rd_idx_ff;
      end
   end

   // saturating finish time update
   assign wr_en  = cmd.write_fresh || cmd.write_acc;
   assign wr_idx = cmd.write_fresh ? used_ff[IDX_W-1:0] : best_idx_ff;
   assign base   = cmd.write_acc ? best_val_ff : '0;
   assign sum    = {1'b0, base} + (TIME_BITS + 1)'(dur_ff);
   assign t_new  = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= t_new;
         asgn_ff     <= wr_idx;
         sat_ff      <= &t_new;
      end
   end

   assign status.is_job    = (opcode_ff == efss_pkg::OP_JOB);
   assign status.used_lt_n = (used_ff < n_eff);
   assign status.scan_done = scan_act_ff && (cnt_ff == n_eff) && !rd_vld_ff;

   // result beat
   assign asgn_num = SW'(asgn_ff) + SW'(1);
   assign used_num = SW'(used_ff) + SW'(1);
   assign best_num = SW'(best_idx_ff) + SW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.resp_clear || cmd.resp_direct || cmd.resp_scan;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_clear) begin
         rsp_asgn_ff <= '0;
         rsp_next_ff <= efss_pkg::FIELD_W'(1);
         rsp_sat_ff  <= 1'b0;
      end else if (cmd.resp_direct || cmd.resp_scan) begin
         rsp_asgn_ff <= asgn_num[efss_pkg::FIELD_W-1:0];
         rsp_next_ff <= cmd.resp_direct ? used_num[efss_pkg::FIELD_W-1:0]
                                        : best_num[efss_pkg::FIELD_W-1:0];
         rsp_sat_ff  <= sat_ff;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_assigned_server = rsp_asgn_ff;
   assign rsp_next_server     = rsp_next_ff;
   assign rsp_time_saturated  = rsp_sat_ff;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the earliest free server select unit. A short directed
// table covers clears, fresh and earliest-finish assignment, tie breaking,
// out-of-range and mid-batch server counts, then random batches under
// several server counts follow. Every result beat is checked against a
// built-in assignment predictor, or against a typed value in the table.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned SRV_MAX       = 16;
   localparam longint unsigned TIME_MAX  = 64'h0000_0000_FFFF_FFFF;
   localparam int unsigned TAIL_CYCLES   = 2 * SRV_MAX + 7;
   localparam int unsigned CYCLE_LIMIT   = 400_000;
   localparam int unsigned RANDOM_ITEMS  = 1450;
   localparam int unsigned MAX_REPORTS   = 10;

   typedef struct packed {
      logic [efss_pkg::FIELD_W-1:0] assigned;
      logic [efss_pkg::FIELD_W-1:0] next;
      logic                         sat;
   } server_pick_type;

   typedef enum logic [1:0] {
      ROW_CFG,
      ROW_PRED,
      ROW_TYPED
   } row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      efss_pkg::opcode_type           op;
      logic [efss_pkg::SERVICE_W-1:0] svc;
      logic [efss_pkg::FIELD_W-1:0]   cfg;
      server_pick_type                want;
   } plan_row_type;

   localparam server_pick_type NO_PICK    = '0;
   localparam server_pick_type CLEAR_PICK = '{5'd0, 5'd1, 1'b0};
   localparam server_pick_type ONE_PICK   = '{5'd1, 5'd1, 1'b0};

   localparam int unsigned PLAN_LEN = 22;
   localparam plan_row_type PLAN [0:PLAN_LEN-1] = '{
      '{ROW_TYPED, efss_pkg::OP_CLEAR, 16'h0000, 5'd0,  CLEAR_PICK},
      '{ROW_TYPED, efss_pkg::OP_JOB,   16'h0000, 5'd0,  ONE_PICK},
      '{ROW_TYPED, efss_pkg::OP_JOB,   16'hFFFF, 5'd0,  ONE_PICK},
      '{ROW_CFG,   efss_pkg::OP_JOB,   16'h0000, 5'd16, NO_PICK},
      '{ROW_PRED,  efss_pkg::OP_JOB,   16'h0005, 5'd0,  NO_PICK},
      '{ROW_PRED,  efss_pkg::OP_JOB,   16'h8000, 5'd0,  NO_PICK},
      '{ROW_PRED,  efss_pkg::OP_JOB,   16'h0001, 5'd0,  NO_PICK},
      '{ROW_CFG,   efss_pkg::OP_JOB,   16'h0000, 5'd0,  NO_PICK},
      '{ROW_PRED,  efss_pkg::OP_JOB,   16'h00FF, 5'd0,  NO_PICK},
      '{ROW_CFG,   efss_pkg::OP_JOB,   16'h0000, 5'd31, NO_PICK},
      '{ROW_PRED,  efss_pkg::OP_JOB,   16'h5555, 5'd0,  NO_PICK},
      '{ROW_PRED,  efss_pkg::OP_JOB,   16'hAAAA, 5'd0,  NO_PICK},
      '{ROW_TYPED, efss_pkg::OP_CLEAR, 16'hFFFF, 5'd0,  CLEAR_PICK},
      '{ROW_CFG,   efss_pkg::OP_JOB,   16'h0000, 5'd3,  NO_PICK},
      '{ROW_PRED,  efss_pkg::OP_JOB,   16'h000A, 5'd0,  NO_PICK},
      '{ROW_PRED,  efss_pkg::OP_JOB,   16'h000A, 5'd0,  NO_PICK},
      '{ROW_PRED,  efss_pkg::OP_JOB,   16'h000A, 5'd0,  NO_PICK},
      '{ROW_PRED,  efss_pkg::OP_JOB,   16'h0000, 5'd0,  NO_PICK},
      '{ROW_PRED,  efss_pkg::OP_JOB,   16'h7FFF, 5'd0,  NO_PICK},
      '{ROW_CFG,   efss_pkg::OP_JOB,   16'h0000, 5'd17, NO_PICK},
      '{ROW_PRED,  efss_pkg::OP_JOB,   16'h0003, 5'd0,  NO_PICK},
      '{ROW_TYPED, efss_pkg::OP_CLEAR, 16'h0000, 5'd0,  CLEAR_PICK}
   };

   localparam int unsigned CFG_LIST_LEN = 8;
   localparam logic [efss_pkg::FIELD_W-1:0] CFG_LIST [0:CFG_LIST_LEN-1] = '{
      5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd8, 5'd15
   };

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic                           req_opcode;
   logic [efss_pkg::SERVICE_W-1:0] req_service_time;
   logic                           rsp_strobe;
   logic [efss_pkg::FIELD_W-1:0]   rsp_assigned_server;
   logic [efss_pkg::FIELD_W-1:0]   rsp_next_server;
   logic                           rsp_time_saturated;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [efss_pkg::FIELD_W-1:0]   csr_num_servers;

   // predictor state
   logic [31:0]                  finish_q [SRV_MAX];
   int unsigned                  used_cnt;
   logic [efss_pkg::FIELD_W-1:0] num_servers_q;

   server_pick_type expected_picks [$];
   int unsigned     err_count;
   int unsigned     cycle_cnt;

   earliest_free_server_select_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_service_time    (req_service_time),
      .rsp_strobe          (rsp_strobe),
      .rsp_assigned_server (rsp_assigned_server),
      .rsp_next_server     (rsp_next_server),
      .rsp_time_saturated  (rsp_time_saturated),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_num_servers     (csr_num_servers)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned active_servers();
      int unsigned n;
      n = 32'(num_servers_q);
      if (n == 0) n = 1;
      if (n > SRV_MAX) n = SRV_MAX;
      return n;
   endfunction

   function automatic int unsigned earliest_server(input int unsigned n);
      int unsigned best;
      best = 0;
      for (int unsigned i = 1; i < n; i++) begin
         if (finish_q[i] < finish_q[best]) best = i;
      end
      return best;
   endfunction

   function automatic server_pick_type predict_pick(
         input efss_pkg::opcode_type op,
         input logic [efss_pkg::SERVICE_W-1:0] svc);
      server_pick_type r;
      int unsigned     n;
      int unsigned     idx;
      longint unsigned t;
      n = active_servers();
      if (op == efss_pkg::OP_CLEAR) begin
         used_cnt = 0;
         return CLEAR_PICK;
      end
      if (used_cnt < n) begin
         idx = used_cnt;
         used_cnt++;
         t = 64'(svc);
      end else begin
         idx = earliest_server(n);
         t = 64'(finish_q[idx]) + 64'(svc);
         if (t > TIME_MAX) t = TIME_MAX;
      end
      finish_q[idx] = t[31:0];
      r.assigned = efss_pkg::FIELD_W'(idx + 1);
      r.next     = (used_cnt < n) ? efss_pkg::FIELD_W'(used_cnt + 1)
                                  : efss_pkg::FIELD_W'(earliest_server(n) + 1);
      r.sat      = (t == TIME_MAX);
      return r;
   endfunction

   task automatic send_command(input efss_pkg::opcode_type op,
                               input logic [efss_pkg::SERVICE_W-1:0] svc,
                               input bit use_typed, input server_pick_type typed_pick,
                               input int unsigned gap);
      server_pick_type p;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_opcode       <= op;
      req_service_time <= svc;
      do @(posedge clock); while (busy);
      p = predict_pick(op, svc);
      expected_picks.push_back(use_typed ? typed_pick : p);
   endtask

   task automatic wait_all_returned();
      start <= 1'b0;
      @(posedge clock);
      while (expected_picks.size() != 0) @(posedge clock);
   endtask

   task automatic write_server_count(input logic [efss_pkg::FIELD_W-1:0] v);
      csr_valid       <= 1'b1;
      csr_num_servers <= v;
      do @(posedge clock); while (!csr_ready);
      num_servers_q = v;
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : rsp_check
      server_pick_type want;
      if (!reset && rsp_strobe) begin
         if (expected_picks.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
               $display("unexpected beat: assigned %0d next %0d sat %0d",
                        rsp_assigned_server, rsp_next_server, rsp_time_saturated);
         end else begin
            want = expected_picks.pop_front();
            if (rsp_assigned_server != want.assigned || rsp_next_server != want.next ||
                rsp_time_saturated != want.sat) begin
               err_count++;
               if (err_count <= MAX_REPORTS)
                  $display("mismatch: assigned %0d/%0d next %0d/%0d sat %0d/%0d (exp/act)",
                           want.assigned, rsp_assigned_server, want.next,
                           rsp_next_server, want.sat, rsp_time_saturated);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("FAIL earliest_free_server_select_unit");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned                    random_sent;
      int unsigned                    phase;
      int unsigned                    batch_len;
      bit                             burst;
      efss_pkg::opcode_type           op;
      logic [efss_pkg::SERVICE_W-1:0] svc;
      used_cnt         = 0;
      num_servers_q    = 5'd1;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_opcode       <= efss_pkg::OP_CLEAR;
      req_service_time <= '0;
      csr_valid        <= 1'b0;
      csr_num_servers  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int unsigned i = 0; i < PLAN_LEN; i++) begin
         if (PLAN[i].kind == ROW_CFG) begin
            wait_all_returned();
            write_server_count(PLAN[i].cfg);
         end else begin
            send_command(PLAN[i].op, PLAN[i].svc, PLAN[i].kind == ROW_TYPED,
                         PLAN[i].want, $urandom_range(0, 16));
         end
      end

      // random batches
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_ITEMS) begin
         wait_all_returned();
         write_server_count(phase < CFG_LIST_LEN ? CFG_LIST[phase]
                            : efss_pkg::FIELD_W'($urandom_range(0, 31)));
         phase++;
         burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) != 0)
            send_command(efss_pkg::OP_CLEAR, 16'($urandom), 1'b0, NO_PICK,
                         burst ? 0 : $urandom_range(0, 16));
         batch_len = $urandom_range(10, 60);
         for (int unsigned k = 0; k < batch_len; k++) begin
            op = ($urandom_range(0, 19) == 0) ? efss_pkg::OP_CLEAR : efss_pkg::OP_JOB;
            case ($urandom_range(0, 5))
               0: svc = 16'h0000;
               1: svc = 16'hFFFF;
               2, 3: svc = 16'($urandom_range(0, 15));
               default: svc = 16'($urandom_range(0, 65535));
            endcase
            if ($urandom_range(0, 63) == 0) wait_all_returned();
            send_command(op, svc, 1'b0, NO_PICK, burst ? 0 : $urandom_range(0, 16));
            random_sent++;
         end
      end

      wait_all_returned();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0 && expected_picks.size() == 0) begin
         $display("PASS earliest_free_server_select_unit");
      end else begin
         $display("FAIL earliest_free_server_select_unit");
      end
      $finish;
   end

endmodule
